// File: rtl/core/dds_pkg.sv
// ----------------------------------------------------------------------------
// DTMF dial sequencer package
// Shared constants, types and the dial symbol decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dds_pkg;

  localparam int MAX_SYMBOLS = 64;
  localparam int IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ON_W = 10;
  localparam int GAP_W = 9;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_ON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE_GAP = 1'd1;
  localparam logic [ON_W-1:0] TONE_ON_RESET = 10'd45;
  localparam logic [GAP_W-1:0] TONE_GAP_RESET = 9'd45;

  localparam logic FUNC_POLL = 1'b0;
  localparam logic FUNC_SYMBOL = 1'b1;

  localparam logic [7:0] SYM_0 = 8'h30;
  localparam logic [7:0] SYM_9 = 8'h39;
  localparam logic [7:0] SYM_A = 8'h41;
  localparam logic [7:0] SYM_D = 8'h44;
  localparam logic [7:0] SYM_STAR = 8'h2A;
  localparam logic [7:0] SYM_HASH = 8'h23;
  localparam logic [7:0] DIGIT_OFS = 8'd32;
  localparam logic [7:0] LETTER_OFS = 8'h27;
  localparam logic [4:0] CODE_STAR = 5'h1E;
  localparam logic [4:0] CODE_HASH = 5'h1F;
  localparam logic [4:0] CODE_OFF = 5'h00;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WRITE = 2'd1,
    PH_ON    = 2'd2,
    PH_GAP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    EV_TONE   = 2'd0,
    EV_REJECT = 2'd1,
    EV_ABORT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic       ok;
    logic [4:0] code;
  } sym_t;

  // One classified beat as it travels from the front to the back.
  typedef struct packed {
    logic        func;
    logic        sym_ok;
    logic [4:0]  code;
    logic        last;
    logic [31:0] now_ms;
    logic        write_ok;
  } item_t;

  function automatic sym_t sym_map(input logic [7:0] ch);
    sym_t       res;
    logic [7:0] diff;
    res = '{ok: 1'b0, code: CODE_OFF};
    diff = 8'h00;
    if (ch inside {[SYM_0:SYM_9]}) begin
      diff = ch - DIGIT_OFS;
      res = '{ok: 1'b1, code: diff[4:0]};
    end else if (ch inside {[SYM_A:SYM_D]}) begin
      diff = ch - LETTER_OFS;
      res = '{ok: 1'b1, code: diff[4:0]};
    end else if (ch == SYM_STAR) begin
      res = '{ok: 1'b1, code: CODE_STAR};
    end else if (ch == SYM_HASH) begin
      res = '{ok: 1'b1, code: CODE_HASH};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dds_front.sv
// ----------------------------------------------------------------------------
// DTMF dial sequencer front end
// Accepts input beats and classifies dial symbols into tone codes.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_front (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          func_i,
  input  wire logic [7:0]    symbol_i,
  input  wire logic          last_symbol_i,
  input  wire logic [31:0]   now_ms_i,
  input  wire logic          write_ok_i,
  output logic               push_o,
  output dds_pkg::item_t     item_o,
  input  wire logic          q_ready_i
);

  dds_pkg::sym_t sym;

  always_comb begin
    sym = dds_pkg::sym_map(symbol_i);
    item_o.func = func_i;
    item_o.sym_ok = sym.ok;
    item_o.code = sym.code;
    item_o.last = last_symbol_i;
    item_o.now_ms = now_ms_i;
    item_o.write_ok = write_ok_i;
  end

  assign in_ready_o = q_ready_i;
  assign push_o = in_valid_i && q_ready_i;

endmodule

`default_nettype wire

// File: rtl/core/dds_queue.sv
// ----------------------------------------------------------------------------
// DTMF dial sequencer queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dds_pkg::item_t item_i,
  output logic                ready_o,
  output logic                valid_o,
  output dds_pkg::item_t      item_o,
  input  wire logic           pop_i
);

  localparam logic [dds_pkg::QCNT_W-1:0] Full = dds_pkg::QCNT_W'(dds_pkg::QUEUE_DEPTH);
  localparam logic [dds_pkg::QPTR_W-1:0] LastPtr =
    dds_pkg::QPTR_W'(dds_pkg::QUEUE_DEPTH - 1);

  dds_pkg::item_t                  entry_q [dds_pkg::QUEUE_DEPTH];
  logic [dds_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dds_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dds_pkg::QCNT_W-1:0]      count_q, count_d;
  logic                            do_push, do_pop;

  assign ready_o = (count_q != Full);
  assign valid_o = (count_q != '0);
  assign item_o = entry_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dds_back.sv
// ----------------------------------------------------------------------------
// DTMF dial sequencer back end
// Loads dial strings into the code store and plays them on poll beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dds_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              q_valid_i,
  input  wire dds_pkg::item_t                    item_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             event_kind_o,
  output logic [4:0]                             tone_code_o,
  output logic                                   busy_res_o
);

  localparam logic [dds_pkg::CNT_W-1:0] MaxCnt = dds_pkg::CNT_W'(dds_pkg::MAX_SYMBOLS);

  logic [dds_pkg::ON_W-1:0]    tone_on_q;
  logic [dds_pkg::GAP_W-1:0]   tone_gap_q;

  dds_pkg::phase_e             phase_q, phase_d;
  logic [31:0]                 start_q, start_d;
  logic [dds_pkg::CNT_W-1:0]   load_count_q, load_count_d;
  logic [dds_pkg::CNT_W-1:0]   length_q, length_d;
  logic [dds_pkg::CNT_W-1:0]   play_idx_q, play_idx_d;
  logic                        load_bad_q, load_bad_d;

  logic [4:0]                  store [dds_pkg::MAX_SYMBOLS];
  logic [4:0]                  rd_code_q;
  logic [dds_pkg::IDX_W-1:0]   rd_addr, wr_addr;
  logic                        mem_we;

  logic                        out_valid_q;
  dds_pkg::kind_e              kind_q, res_kind;
  logic [4:0]                  code_q, res_code;
  logic                        busy_q, res_busy;
  logic                        emit;
  logic [31:0]                 elapsed;
  logic                        bad_now;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);
  assign elapsed = item_i.now_ms - start_q;
  assign wr_addr = load_count_q[dds_pkg::IDX_W-1:0];
  assign rd_addr = play_idx_d[dds_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_on_q <= dds_pkg::TONE_ON_RESET;
      tone_gap_q <= dds_pkg::TONE_GAP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dds_pkg::CFG_TONE_ON:  tone_on_q <= cfg_data_i[dds_pkg::ON_W-1:0];
        dds_pkg::CFG_TONE_GAP: tone_gap_q <= cfg_data_i[dds_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d = phase_q;
    start_d = start_q;
    load_count_d = load_count_q;
    length_d = length_q;
    play_idx_d = play_idx_q;
    load_bad_d = load_bad_q;
    mem_we = 1'b0;
    emit = 1'b0;
    res_kind = dds_pkg::EV_TONE;
    res_code = dds_pkg::CODE_OFF;
    res_busy = 1'b0;
    bad_now = load_bad_q;
    if (pop_o) begin
      if (item_i.func == dds_pkg::FUNC_SYMBOL) begin
        // A symbol beat always stops playback, since the store is being refilled.
        phase_d = dds_pkg::PH_IDLE;
        if (!item_i.sym_ok || (load_count_q >= MaxCnt)) begin
          bad_now = 1'b1;
        end else begin
          mem_we = 1'b1;
          load_count_d = load_count_q + 1'b1;
        end
        load_bad_d = bad_now;
        if (item_i.last) begin
          if (bad_now) begin
            load_count_d = '0;
            load_bad_d = 1'b0;
            emit = 1'b1;
            res_kind = dds_pkg::EV_REJECT;
          end else begin
            length_d = load_count_d;
            play_idx_d = '0;
            load_count_d = '0;
            phase_d = dds_pkg::PH_WRITE;
          end
        end
      end else begin
        case (phase_q)
          dds_pkg::PH_WRITE: begin
            emit = 1'b1;
            res_code = rd_code_q;
            if (!item_i.write_ok) begin
              phase_d = dds_pkg::PH_IDLE;
              res_kind = dds_pkg::EV_ABORT;
            end else begin
              start_d = item_i.now_ms;
              play_idx_d = play_idx_q + 1'b1;
              phase_d = dds_pkg::PH_ON;
              res_busy = 1'b1;
            end
          end
          dds_pkg::PH_ON: begin
            if (elapsed > {22'd0, tone_on_q}) begin
              emit = 1'b1;
              if (!item_i.write_ok) begin
                phase_d = dds_pkg::PH_IDLE;
                res_kind = dds_pkg::EV_ABORT;
              end else if (play_idx_q < length_q) begin
                start_d = item_i.now_ms;
                phase_d = dds_pkg::PH_GAP;
                res_busy = 1'b1;
              end else begin
                phase_d = dds_pkg::PH_IDLE;
              end
            end
          end
          dds_pkg::PH_GAP: begin
            if (elapsed > {23'd0, tone_gap_q}) begin
              phase_d = dds_pkg::PH_WRITE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dds_pkg::PH_IDLE;
      start_q <= '0;
      load_count_q <= '0;
      length_q <= '0;
      play_idx_q <= '0;
      load_bad_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      start_q <= start_d;
      load_count_q <= load_count_d;
      length_q <= length_d;
      play_idx_q <= play_idx_d;
      load_bad_q <= load_bad_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= res_kind;
      code_q <= res_code;
      busy_q <= res_busy;
    end
  end

  // Code store. The read runs one beat ahead on the next play position, and a
  // write to that same entry is forwarded so a fresh string plays its own code.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store[wr_addr] <= item_i.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we && (wr_addr == rd_addr)) begin
      rd_code_q <= item_i.code;
    end else begin
      rd_code_q <= store[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_kind_o = kind_q;
  assign tone_code_o = code_q;
  assign busy_res_o = busy_q;

  a_busy_keeps_dialing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && res_busy |=> phase_q != dds_pkg::PH_IDLE)
    else $error("busy result but dialing stopped");

  a_index_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != dds_pkg::PH_IDLE |-> play_idx_q <= length_q)
    else $error("play position beyond string length");

  a_write_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == dds_pkg::PH_WRITE |-> play_idx_q < length_q)
    else $error("code write with no stored code left");

  a_load_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_count_q <= MaxCnt)
    else $error("load count beyond store depth");

endmodule

`default_nettype wire

// File: rtl/core/dtmf_dial_sequencer.sv
// ----------------------------------------------------------------------------
// DTMF dial sequencer
// Validates DTMF dial strings and plays them as timed tone-code writes.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle, symbol or poll alike, for as long
// as the result side keeps up. A beat passes through the two-entry queue
// between the classifier and the dialing engine, and the result it causes is
// held in an output register until it is taken; the dialing engine's update
// and its one-ahead read of the 64-entry code store set the rate. Configuration
// writes take effect at once and are meant for idle time.
`default_nettype none

module dtmf_dial_sequencer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dds_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dds_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              func_i,
  input  wire logic [7:0]                        symbol_i,
  input  wire logic                              last_symbol_i,
  input  wire logic [31:0]                       now_ms_i,
  input  wire logic                              write_ok_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [1:0]                             event_kind_o,
  output logic [4:0]                             tone_code_o,
  output logic                                   busy_res_o
);

  dds_pkg::item_t  front_item, back_item;
  logic            push, q_ready, q_valid, pop;

  dds_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .now_ms_i      (now_ms_i),
    .write_ok_i    (write_ok_i),
    .push_o        (push),
    .item_o        (front_item),
    .q_ready_i     (q_ready)
  );

  dds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (back_item),
    .pop_i   (pop)
  );

  dds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .q_valid_i    (q_valid),
    .item_i       (back_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .event_kind_o (event_kind_o),
    .tone_code_o  (tone_code_o),
    .busy_res_o   (busy_res_o)
  );

endmodule

`default_nettype wire

// File: tb/dtmf_dial_sequencer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DTMF dial sequencer testbench
// Drives dial strings and time polls through the valid/ready input, mirrors
// the dialing engine in a cycle-free predictor, and checks every result beat
// field by field against the oldest predicted event.
// ----------------------------------------------------------------------------

module dtmf_dial_sequencer_test;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [4:0] CODE_DIGIT_BASE = 5'h10;
  localparam logic [4:0] CODE_LETTER_BASE = 5'h19;

  typedef struct {
    logic        func;
    logic [7:0]  symbol;
    logic        last;
    logic [31:0] now_ms;
    logic        write_ok;
  } dial_beat_t;

  typedef struct {
    dds_pkg::kind_e kind;
    logic [4:0]     code;
    logic           busy;
  } dial_event_t;

  logic                           clk_i;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [dds_pkg::CFG_IDX_W-1:0]  cfg_idx_i = dds_pkg::CFG_TONE_ON;
  logic [dds_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic                           func_i = dds_pkg::FUNC_POLL;
  logic [7:0]                     symbol_i = '0;
  logic                           last_symbol_i = 1'b0;
  logic [31:0]                    now_ms_i = '0;
  logic                           write_ok_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [1:0]                     event_kind_o;
  logic [4:0]                     tone_code_o;
  logic                           busy_res_o;

  // Predictor state of the dialing engine.
  dds_pkg::phase_e dial_state = dds_pkg::PH_IDLE;
  logic [31:0] tone_mark_ms = '0;
  logic [4:0]  dial_codes [dds_pkg::MAX_SYMBOLS];
  logic [6:0]  fill_count = '0;
  logic [6:0]  dial_len = '0;
  logic [6:0]  next_pos = '0;
  logic        fill_error = 1'b0;
  logic [dds_pkg::ON_W-1:0]  on_ms = dds_pkg::TONE_ON_RESET;
  logic [dds_pkg::GAP_W-1:0] gap_ms = dds_pkg::TONE_GAP_RESET;

  dial_event_t pending_events [$];
  logic [31:0] wall_ms;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int          error_count = 0;
  int          beats_sent = 0;
  int          events_checked = 0;
  int          tone_events = 0;
  int          reject_events = 0;
  int          abort_events = 0;

  dtmf_dial_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .symbol_i      (symbol_i),
    .last_symbol_i (last_symbol_i),
    .now_ms_i      (now_ms_i),
    .write_ok_i    (write_ok_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_kind_o  (event_kind_o),
    .tone_code_o   (tone_code_o),
    .busy_res_o    (busy_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_dial_symbol(input logic [7:0] ch);
    return (ch >= dds_pkg::SYM_0 && ch <= dds_pkg::SYM_9) ||
           (ch >= dds_pkg::SYM_A && ch <= dds_pkg::SYM_D) ||
           ch == dds_pkg::SYM_STAR || ch == dds_pkg::SYM_HASH;
  endfunction

  function automatic void expect_event(input dds_pkg::kind_e kind, input logic [4:0] code,
                                       input logic busy);
    dial_event_t ev;
    ev = '{kind: kind, code: code, busy: busy};
    pending_events.push_back(ev);
  endfunction

  function automatic void predict_dial(input dial_beat_t b);
    logic [4:0]  code;
    logic [31:0] elapsed;
    code = dds_pkg::CODE_OFF;
    elapsed = b.now_ms - tone_mark_ms;
    if (b.func == dds_pkg::FUNC_SYMBOL) begin
      // Any symbol stops dialing, since the code store is being refilled.
      dial_state = dds_pkg::PH_IDLE;
      if (!is_dial_symbol(b.symbol) || fill_count >= dds_pkg::MAX_SYMBOLS) begin
        fill_error = 1'b1;
      end else begin
        if (b.symbol <= dds_pkg::SYM_9 && b.symbol >= dds_pkg::SYM_0) begin
          code = CODE_DIGIT_BASE + b.symbol[3:0];
        end else if (b.symbol >= dds_pkg::SYM_A && b.symbol <= dds_pkg::SYM_D) begin
          code = CODE_LETTER_BASE + b.symbol[2:0];
        end else if (b.symbol == dds_pkg::SYM_STAR) begin
          code = dds_pkg::CODE_STAR;
        end else begin
          code = dds_pkg::CODE_HASH;
        end
        dial_codes[fill_count[5:0]] = code;
        fill_count = fill_count + 7'd1;
      end
      if (b.last) begin
        if (fill_error) begin
          fill_count = '0;
          fill_error = 1'b0;
          expect_event(dds_pkg::EV_REJECT, dds_pkg::CODE_OFF, 1'b0);
        end else begin
          dial_len = fill_count;
          next_pos = '0;
          fill_count = '0;
          dial_state = dds_pkg::PH_WRITE;
        end
      end
    end else begin
      case (dial_state)
        dds_pkg::PH_WRITE: begin
          code = dial_codes[next_pos[5:0]];
          if (!b.write_ok) begin
            dial_state = dds_pkg::PH_IDLE;
            expect_event(dds_pkg::EV_ABORT, code, 1'b0);
          end else begin
            tone_mark_ms = b.now_ms;
            next_pos = next_pos + 7'd1;
            dial_state = dds_pkg::PH_ON;
            expect_event(dds_pkg::EV_TONE, code, 1'b1);
          end
        end
        dds_pkg::PH_ON: begin
          if (elapsed > on_ms) begin
            if (!b.write_ok) begin
              dial_state = dds_pkg::PH_IDLE;
              expect_event(dds_pkg::EV_ABORT, dds_pkg::CODE_OFF, 1'b0);
            end else if (next_pos < dial_len) begin
              tone_mark_ms = b.now_ms;
              dial_state = dds_pkg::PH_GAP;
              expect_event(dds_pkg::EV_TONE, dds_pkg::CODE_OFF, 1'b1);
            end else begin
              dial_state = dds_pkg::PH_IDLE;
              expect_event(dds_pkg::EV_TONE, dds_pkg::CODE_OFF, 1'b0);
            end
          end
        end
        dds_pkg::PH_GAP: begin
          // The end of the gap only arms the next write; no result here.
          if (elapsed > gap_ms) dial_state = dds_pkg::PH_WRITE;
        end
        default: begin
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Called right after a rising edge; returns right after the edge at which
  // the beat was accepted, with valid still high.
  task automatic send_beat(input logic func, input logic [7:0] sym, input logic last,
                           input logic [31:0] now, input logic ok);
    dial_beat_t beat;
    beat = '{func: func, symbol: sym, last: last, now_ms: now, write_ok: ok};
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= func;
    symbol_i <= sym;
    last_symbol_i <= last;
    now_ms_i <= now;
    write_ok_i <= ok;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_dial(beat);
    beats_sent++;
  endtask

  task automatic send_dial_string(input int len, input int unsigned bad_pct);
    logic [7:0]  ch;
    int unsigned pick;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < bad_pct) begin
        do ch = 8'($urandom_range(255)); while (is_dial_symbol(ch));
      end else begin
        pick = $urandom_range(15);
        if (pick < 10) ch = dds_pkg::SYM_0 + 8'(pick);
        else if (pick < 14) ch = dds_pkg::SYM_A + 8'(pick - 10);
        else if (pick == 14) ch = dds_pkg::SYM_STAR;
        else ch = dds_pkg::SYM_HASH;
      end
      send_beat(dds_pkg::FUNC_SYMBOL, ch, i == len - 1, $urandom, 1'($urandom_range(1)));
    end
  endtask

  task automatic send_poll();
    logic [31:0] span;
    int unsigned pick;
    span = (on_ms > gap_ms) ? 32'(on_ms) : 32'(gap_ms);
    pick = $urandom_range(99);
    if (pick < 8) begin
      wall_ms = $urandom;
    end else if (pick < 24 && dial_state == dds_pkg::PH_ON) begin
      // Land exactly on the on-time limit or one past it.
      wall_ms = tone_mark_ms + on_ms + $urandom_range(1);
    end else if (pick < 24 && dial_state == dds_pkg::PH_GAP) begin
      wall_ms = tone_mark_ms + gap_ms + $urandom_range(1);
    end else if (pick >= 34) begin
      wall_ms = wall_ms + $urandom_range(span / 2 + 1);
    end
    send_beat(dds_pkg::FUNC_POLL, 8'($urandom), 1'($urandom_range(1)), wall_ms,
              $urandom_range(99) < 96);
  endtask

  task automatic play_polls(input int cap);
    int n;
    n = 0;
    while (n < cap && (n == 0 || dial_state != dds_pkg::PH_IDLE)) begin
      send_poll();
      n++;
    end
  endtask

  // Brings the engine to rest, waits for the last event and writes both
  // timing registers.
  task automatic set_tone_timing(input logic [dds_pkg::CFG_DATA_W-1:0] on_val,
                                 input logic [dds_pkg::CFG_DATA_W-1:0] gap_val);
    if (dial_state != dds_pkg::PH_IDLE || fill_count != 0) begin
      send_beat(dds_pkg::FUNC_SYMBOL, 8'h00, 1'b1, $urandom, 1'b1);
    end
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= dds_pkg::CFG_TONE_ON;
    cfg_data_i <= on_val;
    @(posedge clk_i);
    on_ms = on_val[dds_pkg::ON_W-1:0];
    cfg_idx_i <= dds_pkg::CFG_TONE_GAP;
    cfg_data_i <= gap_val;
    @(posedge clk_i);
    gap_ms = gap_val[dds_pkg::GAP_W-1:0];
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed_cases();
    logic [31:0] t;
    send_beat(dds_pkg::FUNC_POLL, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_beat(dds_pkg::FUNC_SYMBOL, 8'h00, 1'b0, 32'h0000_0000, 1'b0);
    send_beat(dds_pkg::FUNC_SYMBOL, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
    // Lowest and highest tone codes, with the timing crossing the 32-bit wrap.
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_0, 1'b0, $urandom, 1'b0);
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_HASH, 1'b1, $urandom, 1'b1);
    t = 32'hFFFF_FFF0;
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t, 1'b1);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t + on_ms, 1'b1);
    t = t + on_ms + 1;
    send_beat(dds_pkg::FUNC_POLL, 8'hFF, 1'b1, t, 1'b1);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t + gap_ms, 1'b1);
    t = t + gap_ms + 1;
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t, 1'b1);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t, 1'b1);
    // The tone-off write fails.
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t + on_ms + 1, 1'b0);
    // The first tone write fails.
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_STAR, 1'b0, $urandom, 1'b1);
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_9, 1'b0, $urandom, 1'b1);
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_A, 1'b1, $urandom, 1'b1);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t, 1'b0);
    // A symbol arriving mid-dial stops dialing silently; the new string
    // then plays from its own first symbol.
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_0 + 8'd5, 1'b1, $urandom, 1'b0);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t, 1'b1);
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_A + 8'd1, 1'b0, $urandom, 1'b0);
    send_beat(dds_pkg::FUNC_POLL, 8'h00, 1'b0, t + 32'd2000, 1'b1);
    send_beat(dds_pkg::FUNC_SYMBOL, dds_pkg::SYM_D, 1'b1, $urandom, 1'b0);
    wall_ms = t;
    play_polls(60);
  endtask

  task automatic test_overlong_strings();
    send_dial_string(dds_pkg::MAX_SYMBOLS + 1, 0);
    send_dial_string(dds_pkg::MAX_SYMBOLS, 0);
    play_polls(16 * dds_pkg::MAX_SYMBOLS);
  endtask

  task automatic test_random_traffic(input int beats, input int unsigned send_pct,
                                     input int unsigned recv_pct);
    int          stop_at;
    int unsigned pick;
    int          len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(dds_pkg::MAX_SYMBOLS, 7)
                                        : $urandom_range(6, 1);
        send_dial_string(len, 0);
        // Mostly play to the end; sometimes cut in with the next string.
        play_polls(($urandom_range(99) < 90) ? 16 * len + 8 : $urandom_range(6, 1));
      end else if (pick < 85) begin
        if ($urandom_range(7) == 0) begin
          send_dial_string(dds_pkg::MAX_SYMBOLS + $urandom_range(4, 1), 0);
        end else begin
          send_dial_string($urandom_range(6, 1), 30);
        end
        play_polls($urandom_range(4));
      end else begin
        repeat ($urandom_range(4, 1)) begin
          send_beat(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)), $urandom,
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  // The receiver stops for a long stretch while polls keep producing events,
  // so the block fills up and must stall its input.
  task automatic test_result_backlog();
    logic [31:0] span;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HOLD_CYCLES;
    send_dial_string(6, 0);
    span = (on_ms > gap_ms) ? 32'(on_ms) : 32'(gap_ms);
    repeat (40) begin
      wall_ms = wall_ms + span + 1;
      send_beat(dds_pkg::FUNC_POLL, 8'($urandom), 1'($urandom_range(1)), wall_ms, 1'b1);
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_events
    dial_event_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d code=%h busy=%b",
                                  event_kind_o, tone_code_o, busy_res_o));
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        case (want.kind)
          dds_pkg::EV_TONE:   tone_events++;
          dds_pkg::EV_REJECT: reject_events++;
          default:            abort_events++;
        endcase
        if (event_kind_o !== want.kind)
          report_mismatch($sformatf("event_kind %0d, predicted %0d", event_kind_o, want.kind));
        if (tone_code_o !== want.code)
          report_mismatch($sformatf("tone_code %h, predicted %h", tone_code_o, want.code));
        if (busy_res_o !== want.busy)
          report_mismatch($sformatf("busy_res %b, predicted %b", busy_res_o, want.busy));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("[dtmf_dial_sequencer] ERROR");
      $finish;
    end
  end

  initial begin
    wall_ms = $urandom;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 11;
    recv_idle_pct = 45;
    test_directed_cases();
    test_overlong_strings();
    set_tone_timing(10'd40, 10'd20);
    test_random_traffic(250, 11, 45);
    set_tone_timing(10'd1000, 10'd500);
    test_random_traffic(250, 45, 11);
    // All ones: the gap register keeps only its low nine bits.
    set_tone_timing(10'h3FF, 10'h3FF);
    test_random_traffic(250, 0, 0);
    set_tone_timing(10'($urandom_range(1000, 40)), 10'($urandom_range(500, 20)));
    test_result_backlog();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d beats in, %0d events checked (%0d tone writes, %0d rejects, %0d aborts)",
             beats_sent, events_checked, tone_events, reject_events, abort_events);
    $display("summary: %0d mismatches over five timing settings and one output backlog",
             error_count);
    if (error_count == 0) begin
      $display("[dtmf_dial_sequencer] OK");
    end else begin
      $display("[dtmf_dial_sequencer] ERROR");
    end
    $finish;
  end

endmodule
